### design/reb_pkg.sv
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types and constants for the resonator envelope bit detector:
// register codes, reset values, shift amounts and the stage records.
// ----------------------------------------------------------------------------
package reb_pkg;

  // sample width default (low bits of the sample port that are used)
  localparam int unsigned SAMPLE_BITS_DEFAULT = 16;

  // fixed field widths
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned DIFF_W   = 16;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned WIN_W    = 8;
  localparam int unsigned PER_W    = 16;
  localparam int unsigned PEAK_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 16;

  // product of a coefficient and a filter output, and the q14 scaling
  localparam int unsigned PROD_W    = COEF_W + ACC_W;
  localparam int unsigned Q14_SHIFT = 14;

  // envelope and threshold shift amounts
  localparam int unsigned UPPER_LEAK_SHIFT   = 10;
  localparam int unsigned LOWER_LEAK_SHIFT   = 11;
  localparam int unsigned UPPER_ATTACK_SHIFT = 6;
  localparam int unsigned LOWER_ATTACK_SHIFT = 2;
  localparam int unsigned THRESH_SHIFT       = 1;

  // register reset values
  localparam logic signed [COEF_W-1:0] GAIN_RESET    = 16'sd31622;
  localparam logic signed [COEF_W-1:0] DAMPING_RESET = 16'sd16255;
  localparam logic [WIN_W-1:0]         WINDOW_RESET  = 8'd100;
  localparam logic [PER_W-1:0]         PERIOD_RESET  = 16'd4000;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 8'd0,
    REG_DAMPING = 8'd1,
    REG_WINDOW  = 8'd2,
    REG_PERIOD  = 8'd3
  } cfg_reg_e;

  // resonator stage result
  typedef struct packed {
    logic              window_fire;
    logic              period_fire;
    logic [ACC_W-1:0]  energy_sum;
    logic [PEAK_W-1:0] peak;
  } res_stage_t;

  // envelope stage result
  typedef struct packed {
    logic              period_fire;
    logic [ACC_W-1:0]  energy;
    logic [ACC_W-1:0]  upper;
    logic [ACC_W-1:0]  lower;
    logic [PEAK_W-1:0] peak;
  } env_stage_t;

  // threshold stage result
  typedef struct packed {
    logic [ACC_W-1:0]  energy;
    logic [ACC_W-1:0]  threshold;
    logic [ACC_W-1:0]  upper;
    logic [ACC_W-1:0]  lower;
    logic [PEAK_W-1:0] peak;
  } thr_stage_t;

endpackage

### design/reb_resonator.sv
// ----------------------------------------------------------------------------
// reb_resonator
// First difference, two-pole q14 resonator, magnitude accumulation,
// window and period counters and the difference peak tracker.
// ----------------------------------------------------------------------------
module reb_resonator #(
  parameter int unsigned SAMPLE_BITS = reb_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  input  logic signed [reb_pkg::COEF_W-1:0]     gain_i,
  input  logic signed [reb_pkg::COEF_W-1:0]     damping_i,
  input  logic [reb_pkg::WIN_W-1:0]             window_length_i,
  input  logic [reb_pkg::PER_W-1:0]             decision_period_i,
  output reb_pkg::res_stage_t                   res_o
);
  import reb_pkg::*;

  logic signed [DIFF_W-1:0] prev_q;
  logic signed [ACC_W-1:0]  y1_q;
  logic signed [ACC_W-1:0]  y2_q;
  logic [ACC_W-1:0]         acc_q;
  logic [WIN_W-1:0]         win_cnt_q;
  logic [PER_W-1:0]         per_cnt_q;
  logic [PEAK_W-1:0]        run_peak_q;
  logic [PEAK_W-1:0]        lat_peak_q;
  res_stage_t               res_q;

  logic signed [DIFF_W-1:0] cur;
  logic signed [DIFF_W-1:0] diff;
  logic [PEAK_W-1:0]        mag;
  logic [PEAK_W-1:0]        peak_now;
  logic signed [PROD_W-1:0] gain_prod;
  logic signed [PROD_W-1:0] damp_prod;
  logic [ACC_W-1:0]         diff_ext;
  logic [ACC_W-1:0]         y_sum;
  logic [ACC_W-1:0]         y_mag;
  logic [ACC_W-1:0]         acc_sum;
  logic [WIN_W-1:0]         win_cnt_inc;
  logic [PER_W-1:0]         per_cnt_inc;
  logic                     win_fire;
  logic                     per_fire;

  // sign-extend the used sample bits and take the wrapped difference
  assign cur  = DIFF_W'($signed(sample_i));
  assign diff = cur - prev_q;
  assign mag  = diff[DIFF_W-1] ? PEAK_W'(-diff) : PEAK_W'(diff);
  assign peak_now = (mag > run_peak_q) ? mag : run_peak_q;

  // resonator: floor of each q14 product is the arithmetic shift
  assign gain_prod = gain_i * y1_q;
  assign damp_prod = damping_i * y2_q;
  assign diff_ext  = ACC_W'(diff);
  assign y_sum     = diff_ext + gain_prod[Q14_SHIFT+ACC_W-1:Q14_SHIFT]
                   - damp_prod[Q14_SHIFT+ACC_W-1:Q14_SHIFT];
  assign y_mag     = y_sum[ACC_W-1] ? (ACC_W'(0) - y_sum) : y_sum;
  assign acc_sum   = acc_q + y_mag;

  // window and period counters, wrapping at their width
  assign win_cnt_inc = win_cnt_q + WIN_W'(1);
  assign per_cnt_inc = per_cnt_q + PER_W'(1);
  assign win_fire    = (win_cnt_inc == window_length_i);
  assign per_fire    = (per_cnt_inc == decision_period_i);

  // per-transaction state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      y1_q       <= '0;
      y2_q       <= '0;
      acc_q      <= '0;
      win_cnt_q  <= '0;
      per_cnt_q  <= '0;
      run_peak_q <= '0;
      lat_peak_q <= '0;
    end else if (load_i) begin
      prev_q     <= cur;
      y2_q       <= y1_q;
      y1_q       <= $signed(y_sum);
      acc_q      <= win_fire ? '0 : acc_sum;
      win_cnt_q  <= win_fire ? '0 : win_cnt_inc;
      per_cnt_q  <= per_fire ? '0 : per_cnt_inc;
      run_peak_q <= per_fire ? '0 : peak_now;
      lat_peak_q <= per_fire ? peak_now : lat_peak_q;
    end
  end

  // stage result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q.window_fire <= win_fire;
      res_q.period_fire <= per_fire;
      res_q.energy_sum  <= acc_sum;
      res_q.peak        <= per_fire ? peak_now : lat_peak_q;
    end
  end

  assign res_o = res_q;

endmodule

### design/reb_envelope.sv
// ----------------------------------------------------------------------------
// reb_envelope
// Latches the window energy and moves the upper and lower envelopes by
// leak and attack shifts at each window end.
// ----------------------------------------------------------------------------
module reb_envelope (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  reb_pkg::res_stage_t res_i,
  output reb_pkg::env_stage_t env_o
);
  import reb_pkg::*;

  logic [ACC_W-1:0] energy_q;
  logic [ACC_W-1:0] upper_q;
  logic [ACC_W-1:0] lower_q;
  env_stage_t       env_q;

  logic [ACC_W-1:0] energy_d;
  logic [ACC_W-1:0] upper_d;
  logic [ACC_W-1:0] lower_d;
  logic [ACC_W-1:0] upper_leak;
  logic [ACC_W-1:0] lower_leak;
  logic [ACC_W-1:0] upper_gap;
  logic [ACC_W-1:0] lower_gap;

  // leak step from the old levels, then attack toward the new energy
  always_comb begin
    upper_leak = upper_q + ACC_W'($signed(lower_q - upper_q) >>> UPPER_LEAK_SHIFT);
    lower_leak = lower_q + ACC_W'($signed(upper_q - lower_q) >>> LOWER_LEAK_SHIFT);
    upper_gap  = res_i.energy_sum - upper_leak;
    lower_gap  = res_i.energy_sum - lower_leak;
    energy_d   = energy_q;
    upper_d    = upper_q;
    lower_d    = lower_q;
    if (res_i.window_fire) begin
      energy_d = res_i.energy_sum;
      upper_d  = (upper_leak < res_i.energy_sum)
               ? upper_leak + ACC_W'($signed(upper_gap) >>> UPPER_ATTACK_SHIFT)
               : upper_leak;
      lower_d  = (lower_leak > res_i.energy_sum)
               ? lower_leak + ACC_W'($signed(lower_gap) >>> LOWER_ATTACK_SHIFT)
               : lower_leak;
    end
  end

  // envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
      upper_q  <= '0;
      lower_q  <= '0;
    end else if (load_i) begin
      energy_q <= energy_d;
      upper_q  <= upper_d;
      lower_q  <= lower_d;
    end
  end

  // stage result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      env_q.period_fire <= res_i.period_fire;
      env_q.energy      <= energy_d;
      env_q.upper       <= upper_d;
      env_q.lower       <= lower_d;
      env_q.peak        <= res_i.peak;
    end
  end

  assign env_o = env_q;

endmodule

### design/reb_threshold.sv
// ----------------------------------------------------------------------------
// reb_threshold
// Moves the slicing threshold halfway toward the envelope midpoint once
// per decision period.
// ----------------------------------------------------------------------------
module reb_threshold (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  reb_pkg::env_stage_t env_i,
  output reb_pkg::thr_stage_t thr_o
);
  import reb_pkg::*;

  logic [ACC_W-1:0] thresh_q;
  thr_stage_t       thr_q;

  logic [ACC_W-1:0] mid;
  logic [ACC_W-1:0] thresh_d;

  // midpoint uses a logical halving of the envelope gap
  assign mid      = env_i.lower + ((env_i.upper - env_i.lower) >> 1);
  assign thresh_d = env_i.period_fire
                  ? thresh_q + ACC_W'($signed(mid - thresh_q) >>> THRESH_SHIFT)
                  : thresh_q;

  // threshold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (load_i) begin
      thresh_q <= thresh_d;
    end
  end

  // stage result register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      thr_q.energy    <= env_i.energy;
      thr_q.threshold <= thresh_d;
      thr_q.upper     <= env_i.upper;
      thr_q.lower     <= env_i.lower;
      thr_q.peak      <= env_i.peak;
    end
  end

  assign thr_o = thr_q;

endmodule

### design/resonator_envelope_bit_detector_top.sv
// Stages: input register, resonator, envelope, threshold, output register.
// Throughput: one sample per cycle when not stalled, set by the resonator feedback
// (two coefficient by filter output multiplies feeding the next sample).
// Reset: all filter, envelope, threshold and counter state clears to zero and
// the configuration registers take their default values; no clearing pass.
// ----------------------------------------------------------------------------
// resonator_envelope_bit_detector_top
// Input register, resonator, envelope and threshold stages and the output
// register, with valid/stall flow control and a configuration write port.
// ----------------------------------------------------------------------------
module resonator_envelope_bit_detector_top #(
  parameter int unsigned SAMPLE_BITS = reb_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [15:0]                sample_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              carrier_bit_o,
  output logic [31:0]                       window_energy_o,
  output logic [31:0]                       decision_threshold_o,
  output logic [31:0]                       upper_envelope_o,
  output logic [31:0]                       lower_envelope_o,
  output logic [15:0]                       peak_difference_o,
  // configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [reb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [reb_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import reb_pkg::*;

  // configuration registers
  logic signed [COEF_W-1:0] gain_q;
  logic signed [COEF_W-1:0] damping_q;
  logic [WIN_W-1:0]         window_q;
  logic [PER_W-1:0]         period_q;

  // pipeline valid flags and input register
  logic                   v0_q;
  logic                   v1_q;
  logic                   v2_q;
  logic                   v3_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  // output register
  logic             carrier_q;
  logic [ACC_W-1:0] energy_q;
  logic [ACC_W-1:0] thresh_q;
  logic [ACC_W-1:0] upper_q;
  logic [ACC_W-1:0] lower_q;
  logic [PEAK_W-1:0] peak_q;

  logic       out_ready;
  logic       s3_ready;
  logic       s2_ready;
  logic       s1_ready;
  logic       s0_ready;
  logic       mv1;
  logic       mv2;
  logic       mv3;
  logic       mvo;
  res_stage_t res_s;
  env_stage_t env_s;
  thr_stage_t thr_s;

  // configuration writes, always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      damping_q <= DAMPING_RESET;
      window_q  <= WINDOW_RESET;
      period_q  <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN:    gain_q    <= $signed(cfg_data_i);
        REG_DAMPING: damping_q <= $signed(cfg_data_i);
        REG_WINDOW:  window_q  <= cfg_data_i[WIN_W-1:0];
        REG_PERIOD:  period_q  <= cfg_data_i[PER_W-1:0];
        default:     ;
      endcase
    end
  end

  // flow control: a stage takes a transaction when empty or draining
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s3_ready   = !v3_q || out_ready;
  assign s2_ready   = !v2_q || s3_ready;
  assign s1_ready   = !v1_q || s2_ready;
  assign s0_ready   = !v0_q || s1_ready;
  assign in_stall_o = !s0_ready;

  assign mv1 = v0_q && s1_ready;
  assign mv2 = v1_q && s2_ready;
  assign mv3 = v2_q && s3_ready;
  assign mvo = v3_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_ready)  v0_q        <= in_valid_i;
      if (s1_ready)  v1_q        <= v0_q;
      if (s2_ready)  v2_q        <= v1_q;
      if (s3_ready)  v3_q        <= v2_q;
      if (out_ready) out_valid_q <= v3_q;
    end
  end

  // input register keeps only the used sample bits
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s0_ready) begin
      sample_q <= sample_i[SAMPLE_BITS-1:0];
    end
  end

  reb_resonator #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_resonator (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (mv1),
    .sample_i         (sample_q),
    .gain_i           (gain_q),
    .damping_i        (damping_q),
    .window_length_i  (window_q),
    .decision_period_i(period_q),
    .res_o            (res_s)
  );

  reb_envelope u_envelope (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(mv2),
    .res_i (res_s),
    .env_o (env_s)
  );

  reb_threshold u_threshold (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(mv3),
    .env_i (env_s),
    .thr_o (thr_s)
  );

  // output register with the energy slicer
  always_ff @(posedge clk_i) begin
    if (mvo) begin
      carrier_q <= (thr_s.energy > thr_s.threshold);
      energy_q  <= thr_s.energy;
      thresh_q  <= thr_s.threshold;
      upper_q   <= thr_s.upper;
      lower_q   <= thr_s.lower;
      peak_q    <= thr_s.peak;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign carrier_bit_o        = carrier_q;
  assign window_energy_o      = energy_q;
  assign decision_threshold_o = thresh_q;
  assign upper_envelope_o     = upper_q;
  assign lower_envelope_o     = lower_q;
  assign peak_difference_o    = peak_q;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the resonator envelope bit detector. A bit-exact
// carrier slicer in the bench predicts every result transaction. Flow control
// on both channels is randomised, and the registers are changed between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
  import reb_pkg::*;

  localparam int unsigned PIPE_LATENCY = 4;
  localparam int unsigned STALL_LIMIT  = 2000;
  // index with no register behind it, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_e;

  // one result transaction
  typedef struct {
    logic        carrier;
    logic [31:0] energy;
    logic [31:0] threshold;
    logic [31:0] upper;
    logic [31:0] lower;
    logic [15:0] peak;
  } slice_t;

  // bit-exact carrier slicer with its own copy of state and registers
  class carrier_slicer;
    logic signed [15:0] gain;
    logic signed [15:0] damping;
    logic [7:0]         win_len;
    logic [15:0]        period;
    logic [15:0]        last_sample;
    logic [31:0]        y1, y2, energy_sum, energy, upper, lower, threshold;
    logic [7:0]         win_cnt;
    logic [15:0]        per_cnt;
    logic [16:0]        run_peak, peak;
    slice_t             expected_slices[$];
    int unsigned        mismatches, samples, window_closes, decisions, carrier_ones;

    function new();
      gain          = GAIN_RESET;
      damping       = DAMPING_RESET;
      win_len       = WINDOW_RESET;
      period        = PERIOD_RESET;
      last_sample   = '0;
      y1            = '0;
      y2            = '0;
      energy_sum    = '0;
      energy        = '0;
      upper         = '0;
      lower         = '0;
      threshold     = '0;
      win_cnt       = '0;
      per_cnt       = '0;
      run_peak      = '0;
      peak          = '0;
      mismatches    = 0;
      samples       = 0;
      window_closes = 0;
      decisions     = 0;
      carrier_ones  = 0;
    endfunction

    function logic [31:0] asr(logic [31:0] x, int unsigned s);
      return $signed(x) >>> s;
    endfunction

    // floor(coef * hist / 2^14), kept to 32 bits
    function logic [31:0] q14_term(logic signed [15:0] c, logic [31:0] h);
      longint prod;
      prod = longint'(c) * longint'($signed(h));
      return prod[31+Q14_SHIFT:Q14_SHIFT];
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_GAIN:    gain = data;
        REG_DAMPING: damping = data;
        REG_WINDOW:  win_len = data[7:0];
        REG_PERIOD:  period = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_slices.size();
    endfunction

    // accepted sample in, expected result queued
    function void take_sample(logic signed [15:0] s);
      logic [15:0]        diff;
      logic signed [16:0] dx;
      logic [16:0]        mag;
      logic [31:0]        y, ymag, pu, pl, mid;
      slice_t             want;
      diff = s - last_sample;
      last_sample = s;
      dx = $signed(diff);
      mag = dx[16] ? -dx : dx;
      if (mag > run_peak) run_peak = mag;

      // two-pole resonator on the first difference
      y = {{15{dx[16]}}, dx} + q14_term(gain, y1) - q14_term(damping, y2);
      y2 = y1;
      y1 = y;
      ymag = y[31] ? 32'd0 - y : y;
      energy_sum += ymag;

      // window end: latch energy, leak and attack the envelopes
      win_cnt += 8'd1;
      if (win_cnt == win_len) begin
        pu = upper;
        pl = lower;
        win_cnt = '0;
        energy = energy_sum;
        energy_sum = '0;
        upper = pu + asr(pl - pu, UPPER_LEAK_SHIFT);
        lower = pl + asr(pu - pl, LOWER_LEAK_SHIFT);
        if (upper < energy) upper += asr(energy - upper, UPPER_ATTACK_SHIFT);
        if (lower > energy) lower += asr(energy - lower, LOWER_ATTACK_SHIFT);
        window_closes++;
      end

      // decision period end: threshold towards the midpoint, latch peak
      per_cnt += 16'd1;
      if (per_cnt == period) begin
        mid = lower + ((upper - lower) >> 1);
        per_cnt = '0;
        threshold += asr(mid - threshold, THRESH_SHIFT);
        peak = run_peak;
        run_peak = '0;
        decisions++;
      end

      want.carrier   = energy > threshold;
      want.energy    = energy;
      want.threshold = threshold;
      want.upper     = upper;
      want.lower     = lower;
      want.peak      = peak[15:0];
      if (want.carrier) carrier_ones++;
      expected_slices.push_back(want);
      samples++;
    endfunction

    function void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0h, got %0h", name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(slice_t got);
      slice_t want;
      if (expected_slices.size() == 0) begin
        $error("result transaction with no sample outstanding");
        mismatches++;
        return;
      end
      want = expected_slices.pop_front();
      check_field("carrier_bit", want.carrier, got.carrier);
      check_field("window_energy", want.energy, got.energy);
      check_field("decision_threshold", want.threshold, got.threshold);
      check_field("upper_envelope", want.upper, got.upper);
      check_field("lower_envelope", want.lower, got.lower);
      check_field("peak_difference", want.peak, got.peak);
    endfunction
  endclass

  // clock, reset and block inputs
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic signed [15:0]    sample_i    = '0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i  = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  carrier_bit_o;
  logic [31:0]           window_energy_o;
  logic [31:0]           decision_threshold_o;
  logic [31:0]           upper_envelope_o;
  logic [31:0]           lower_envelope_o;
  logic [15:0]           peak_difference_o;
  logic                  cfg_ready_o;

  carrier_slicer slicer = new();
  slice_t        seen_slice;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   quiet_cycles   = 0;
  int unsigned   settings_done  = 0;

  // am tone generator state
  int tone_pos = 0;
  int tone_len = 24;
  int tone_amp = 10000;
  int seg_left = 0;
  bit tone_on  = 1'b0;

  // steps across the full scale, wrapped differences both ways
  logic signed [15:0] corner_samples[8] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh0000,
                                             16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};

  resonator_envelope_bit_detector_top uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .sample_i             (sample_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .carrier_bit_o        (carrier_bit_o),
    .window_energy_o      (window_energy_o),
    .decision_threshold_o (decision_threshold_o),
    .upper_envelope_o     (upper_envelope_o),
    .lower_envelope_o     (lower_envelope_o),
    .peak_difference_o    (peak_difference_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check each accepted transaction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_slice.carrier   = carrier_bit_o;
      seen_slice.energy    = window_energy_o;
      seen_slice.threshold = decision_threshold_o;
      seen_slice.upper     = upper_envelope_o;
      seen_slice.lower     = lower_envelope_o;
      seen_slice.peak      = peak_difference_o;
      slicer.check_result(seen_slice);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             quiet_cycles, slicer.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // one register write; valid stays high for a following write
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    slicer.set_register(idx, data);
  endtask

  // all four registers plus a write to the unmapped index
  task automatic load_settings(input logic signed [15:0] g, input logic signed [15:0] d,
                               input logic [7:0] w, input logic [15:0] p);
    write_register(REG_GAIN, g);
    write_register(REG_DAMPING, d);
    write_register(REG_WINDOW, {8'($urandom()), w});
    write_register(REG_PERIOD, p);
    write_register(REG_UNMAPPED, 16'($urandom()));
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic send_sample(input logic signed [15:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    slicer.take_sample(s);
  endtask

  // hold off the sender until every result is back and the pipe is empty
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (slicer.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // mostly am-keyed tone bursts, the rest noise and full-scale values
  function automatic logic signed [15:0] next_sample();
    int kind;
    int ramp;
    int level;
    kind = $urandom_range(99);
    if (seg_left == 0) begin
      tone_on  = !tone_on;
      seg_left = $urandom_range(200, 20);
      tone_amp = $urandom_range(30000, 500);
      tone_len = $urandom_range(28, 18);
    end
    seg_left--;
    tone_pos = (tone_pos + 1) % tone_len;
    if (kind < 55) begin
      ramp  = (tone_pos < tone_len / 2) ? tone_pos : tone_len - tone_pos;
      level = tone_on ? tone_amp * (4 * ramp - tone_len) / tone_len : 0;
      return 16'(level + int'($urandom_range(64)) - 32);
    end else if (kind < 75) begin
      return 16'($urandom());
    end else if (kind < 90) begin
      return 16'(int'($urandom_range(64)) - 32);
    end
    case ($urandom_range(3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic run_phase(input logic signed [15:0] g, input logic signed [15:0] d,
                           input logic [7:0] w, input logic [15:0] p,
                           input flow_e flow, input int unsigned count);
    load_settings(g, d, w, p);
    send_idle_pct  = (flow == FLOW_SEND_IDLE) ? 61 : (flow == FLOW_BOTH) ? 19 : 0;
    recv_stall_pct = (flow == FLOW_RECV_STALL) ? 61 : (flow == FLOW_BOTH) ? 19 : 0;
    repeat (count) send_sample(next_sample());
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // gain of exactly -2 and no damping: one full-negative difference then
    // silence doubles the output until it lands on the most negative value
    load_settings(-16'sd32768, 16'sd0, 8'd5, 16'd6);
    repeat (17) send_sample(-16'sh8000);
    wait_for_results();

    // full-scale steps with short window and period
    load_settings(GAIN_RESET, DAMPING_RESET, 8'd3, 16'd4);
    foreach (corner_samples[i]) send_sample(corner_samples[i]);
    wait_for_results();

    // random phases, with window and period lengths both below and above the count
    run_phase(GAIN_RESET, DAMPING_RESET, 8'd1, 16'd1, FLOW_FREE, 100);
    run_phase(16'sd32767, -16'sd32768, 8'd255, 16'd65535, FLOW_SEND_IDLE, 100);
    run_phase(GAIN_RESET, DAMPING_RESET, 8'd7, 16'd37, FLOW_RECV_STALL, 120);
    run_phase(16'sd0, 16'sd32767, 8'd0, 16'd300, FLOW_BOTH, 150);
    run_phase(-16'sd32768, -16'sd32768, 8'd3, 16'd2, FLOW_FREE, 80);
    run_phase(16'sd20000, 16'sd15000, 8'd16, 16'd50, FLOW_RECV_STALL, 150);
    run_phase(16'sd30000, 16'sd16000, 8'd20, 16'd0, FLOW_BOTH, 100);

    if (slicer.pending() != 0) begin
      $error("%0d expected results never arrived", slicer.pending());
      slicer.mismatches++;
    end
    $display("run: %0d samples over %0d register settings, %0d windows closed, %0d decisions",
             slicer.samples, settings_done, slicer.window_closes, slicer.decisions);
    $display("carrier bit high in %0d results, %0d mismatches",
             slicer.carrier_ones, slicer.mismatches);
    if (slicer.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
